// ===== rtl/pgpc_pkg.sv =====
// shared types and constants of the pixel gain and pedestal corrector
package pgpc_pkg;

   localparam int GAIN_STAGES = 3;
   localparam int GAIN_W = 24;
   localparam int PED_W = 20;
   localparam int ADC_W = 14;
   localparam int NUM_W = 36;
   localparam int DEN_W = 25;
   localparam int QEXT_W = NUM_W + 1;

   localparam logic OP_CORRECT = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [1:0] GAIN_CODE_INVALID = 2'd2;
   localparam logic [1:0] GAIN_CODE_HIGH = 2'd3;
   localparam logic [1:0] STAGE_HIGH = 2'd2;
   localparam logic [1:0] STAGE_LOW = 2'd0;

   typedef enum logic [1:0] {
      STATUS_NORMAL = 2'd0,
      STATUS_INVALID_GAIN = 2'd1,
      STATUS_ZERO_GAIN = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   typedef struct packed {
      logic operation;
      logic [18:0] pixel_index;
      logic [15:0] raw_sample;
      logic [1:0] stage;
      logic signed [23:0] gain_coeff;
      logic signed [19:0] pedestal_coeff;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] corrected_value;
      logic [1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic output_wide;
   } csr_payload_type;

   typedef struct packed {
      logic valid;
      logic neg;
      status_type status;
   } tag_type;

endpackage

// ===== rtl/pgpc_chan_if.sv =====
// valid/ready channel carrying one payload per transaction
interface pgpc_chan_if #(parameter type payload_type = logic);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/pgpc_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
module pgpc_div
   import pgpc_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic enable,
   input tag_type in_tag,
   input logic [NUM_W-1:0] in_num,
   input logic [DEN_W-1:0] in_den,
   output tag_type out_tag,
   output logic [NUM_W-1:0] out_quo
);

   tag_type tag_ff [NUM_W];
   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      tag_type tag_cur;
      logic [NUM_W-1:0] num_cur;
      logic [NUM_W-1:0] quo_cur;
      logic [DEN_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;

      if (k == 0) begin : g_first
         assign tag_cur = in_tag;
         assign num_cur = in_num;
         assign quo_cur = '0;
         assign rem_cur = '0;
         assign den_cur = in_den;
      end else begin : g_next
         assign tag_cur = tag_ff[k-1];
         assign num_cur = num_ff[k-1];
         assign quo_cur = quo_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
      end

      assign trial = {rem_cur, num_cur[NUM_W-1]};
      assign diff = trial - {1'b0, den_cur};

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else if (enable) begin
            tag_ff[k] <= tag_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[k] <= {num_cur[NUM_W-2:0], 1'b0};
            den_ff[k] <= den_cur;
            quo_ff[k] <= {quo_cur[NUM_W-2:0], ~diff[DEN_W]};
            rem_ff[k] <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
         end
      end
   end

   assign out_tag = tag_ff[NUM_W-1];
   assign out_quo = quo_ff[NUM_W-1];

endmodule

// ===== rtl/pixel_gain_pedestal_correct.sv =====
// top level of the multi-gain pixel corrector
// Takes one transaction per cycle while no result stalls, correction or calibration write,
// and delivers a corrected pixel through s0, s1, the pipelined 36-stage divider and rsp_ff.
// A calibration write is visible to the next transaction. Calibration is held in one
// synchronous memory of 3*PIXEL_COUNT entries of gain and pedestal; an entry read before it
// was written gives an undefined result. A stalled result holds the whole pipeline.
module pixel_gain_pedestal_correct
   import pgpc_pkg::*;
#(
   parameter int PIXEL_COUNT = 524288
)
(
   input logic clock,
   input logic reset,
   pgpc_chan_if.sink req_ch,
   pgpc_chan_if.source rsp_ch,
   pgpc_chan_if.sink csr_ch
);

   localparam int DEPTH = GAIN_STAGES * PIXEL_COUNT;
   localparam int ADDR_W = $clog2(DEPTH);

   logic advance;
   logic req_accept;
   logic pix_ok;
   logic [1:0] gain_code;
   logic [1:0] rd_stage;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   logic [GAIN_W+PED_W-1:0] cal_mem [DEPTH];
   logic [GAIN_W+PED_W-1:0] rd_ff;

   logic output_wide_ff;
   logic s0_valid_ff;
   logic s0_invalid_ff;
   logic [ADC_W-1:0] s0_adc_ff;

   logic signed [GAIN_W-1:0] gain;
   logic signed [PED_W-1:0] ped;
   logic [21:0] n_val;
   logic [NUM_W-1:0] num;
   tag_type s1_tag_in;
   tag_type s1_tag_ff;
   logic [NUM_W-1:0] s1_num_ff;
   logic [DEN_W-1:0] s1_den_ff;

   tag_type div_tag;
   logic [NUM_W-1:0] div_quo;
   logic [QEXT_W-1:0] q_val;
   logic [QEXT_W-1:0] vmax;
   logic [QEXT_W-1:0] vmin;
   rsp_payload_type rsp_in;

   logic rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign req_accept = req_ch.valid && advance;
   assign csr_ch.ready = 1'b1;

   assign pix_ok = 32'(req_ch.payload.pixel_index) < 32'(PIXEL_COUNT);
   assign gain_code = req_ch.payload.raw_sample[15:14];

   always_comb begin
      case (gain_code)
         GAIN_CODE_HIGH: rd_stage = STAGE_HIGH;
         GAIN_CODE_INVALID: rd_stage = STAGE_LOW;
         default: rd_stage = gain_code;
      endcase
   end

   assign wr_addr = ADDR_W'(req_ch.payload.stage) * ADDR_W'(PIXEL_COUNT)
                    + ADDR_W'(req_ch.payload.pixel_index);
   assign rd_addr = pix_ok ? ADDR_W'(rd_stage) * ADDR_W'(PIXEL_COUNT)
                             + ADDR_W'(req_ch.payload.pixel_index) : '0;

   // calibration memory
   always_ff @(posedge clock) begin
      if (req_accept && req_ch.payload.operation == OP_WRITE && pix_ok
          && 32'(req_ch.payload.stage) < 32'(GAIN_STAGES)) begin
         cal_mem[wr_addr] <= {req_ch.payload.gain_coeff, req_ch.payload.pedestal_coeff};
      end
      if (advance) begin
         rd_ff <= cal_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_wide_ff <= 1'b1;
      end else if (csr_ch.valid) begin
         output_wide_ff <= csr_ch.payload.output_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_tag_ff.valid <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_accept && req_ch.payload.operation == OP_CORRECT && pix_ok;
         s1_tag_ff <= s1_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_invalid_ff <= gain_code == GAIN_CODE_INVALID;
         s0_adc_ff <= req_ch.payload.raw_sample[ADC_W-1:0];
         s1_num_ff <= num[NUM_W-1] ? NUM_W'(-num) : num;
         s1_den_ff <= gain[GAIN_W-1] ? DEN_W'(-{gain, 1'b0}) : {gain, 1'b0};
      end
   end

   // numerator n*8192 + g with n = adc*16 - pedestal
   assign gain = rd_ff[GAIN_W+PED_W-1:PED_W];
   assign ped = rd_ff[PED_W-1:0];
   assign n_val = {4'b0, s0_adc_ff, 4'b0} - {{2{ped[PED_W-1]}}, ped};
   assign num = {n_val[21], n_val, 13'b0} + {{(NUM_W-GAIN_W){gain[GAIN_W-1]}}, gain};

   always_comb begin
      s1_tag_in.valid = s0_valid_ff;
      s1_tag_in.neg = num[NUM_W-1] ^ gain[GAIN_W-1];
      if (s0_invalid_ff) begin
         s1_tag_in.status = STATUS_INVALID_GAIN;
      end else if (gain == '0) begin
         s1_tag_in.status = STATUS_ZERO_GAIN;
      end else begin
         s1_tag_in.status = STATUS_NORMAL;
      end
   end

   pgpc_div u_div (
      .clock(clock),
      .reset(reset),
      .enable(advance),
      .in_tag(s1_tag_ff),
      .in_num(s1_num_ff),
      .in_den(s1_den_ff),
      .out_tag(div_tag),
      .out_quo(div_quo)
   );

   // sign, special markers and saturation
   assign q_val = div_tag.neg ? -{1'b0, div_quo} : {1'b0, div_quo};
   assign vmax = output_wide_ff ? QEXT_W'(32'h7fffffff) : QEXT_W'(16'h7fff);
   assign vmin = ~vmax;

   always_comb begin
      rsp_in.status = div_tag.status;
      rsp_in.corrected_value = q_val[31:0];
      case (div_tag.status)
         STATUS_INVALID_GAIN: rsp_in.corrected_value = 32'(vmax - QEXT_W'(16));
         STATUS_ZERO_GAIN: rsp_in.corrected_value = 32'(vmin + QEXT_W'(16));
         default: begin
            if ($signed(q_val) > $signed(vmax)) begin
               rsp_in.corrected_value = vmax[31:0];
               rsp_in.status = STATUS_SATURATED;
            end else if ($signed(q_val) < $signed(vmin)) begin
               rsp_in.corrected_value = vmin[31:0];
               rsp_in.status = STATUS_SATURATED;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

endmodule
